### design/button_debounce_long_press_macros.svh
// Assertion macros shared by the button debounce block.
// Included by the top level; no other dependencies.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BDLP_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("bdlp assertion failed");

// Next-cycle implication, disabled during reset.
`define BDLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("bdlp assertion failed");

`endif

### design/bdlp_pkg.sv
// Package for the button debounce / long press block: widths, event codes,
// lane indexes, register indexes and the structs passed between modules.
package bdlp_pkg;

  localparam int TimeBits   = 32;
  localparam int CfgBits    = 16;
  localparam int CfgIdxBits = 1;
  localparam int EvBits     = 3;
  localparam int NumLanes   = 3;

  localparam logic [CfgIdxBits-1:0] RegDebounce  = 1'b0;
  localparam logic [CfgIdxBits-1:0] RegLongPress = 1'b1;

  localparam logic [CfgBits-1:0] DebounceReset  = 16'd30;
  localparam logic [CfgBits-1:0] LongPressReset = 16'd1000;

  localparam logic [EvBits-1:0] EvNone     = 3'd0;
  localparam logic [EvBits-1:0] EvPrev     = 3'd1;
  localparam logic [EvBits-1:0] EvNext     = 3'd2;
  localparam logic [EvBits-1:0] EvHome     = 3'd3;
  localparam logic [EvBits-1:0] EvHomeLong = 3'd4;

  localparam int LanePrev = 0;
  localparam int LaneNext = 1;
  localparam int LaneHome = 2;

  // What one lane saw on the current sample.
  typedef struct packed {
    logic held;     // raw level has held for the debounce time
    logic press;    // stable level went to pressed
    logic lift;     // stable level went to released
    logic level;    // stable level after this sample (0 pressed)
  } lane_evt_t;

  typedef struct packed {
    logic              long_done;
    logic [EvBits-1:0] pending;
  } merge_status_t;

endpackage

### design/bdlp_sample_if.sv
// Channel interface for the sample input.
// Depends on bdlp_pkg.
interface bdlp_sample_if;
  import bdlp_pkg::*;
  logic                valid;
  logic                ready;
  logic [TimeBits-1:0] now_ms;
  logic                prev_raw;
  logic                next_raw;
  logic                home_raw;
  logic                take_event;

  modport source (output valid, now_ms, prev_raw, next_raw, home_raw, take_event,
                  input ready);
  modport sink   (input valid, now_ms, prev_raw, next_raw, home_raw, take_event,
                  output ready);
endinterface

### design/bdlp_result_if.sv
// Result channel interface carrying the reported event.
// Depends on bdlp_pkg.
interface bdlp_result_if;
  import bdlp_pkg::*;
  logic              valid;
  logic              ready;
  logic [EvBits-1:0] event_res;

  modport source (output valid, event_res, input ready);
  modport sink   (input valid, event_res, output ready);
endinterface

### design/bdlp_lane.sv
// One debounce lane: raw level tracking, change timer and stable level.
// Depends on bdlp_pkg.
module bdlp_lane (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          accept,
  input  logic                          raw,
  input  logic [bdlp_pkg::TimeBits-1:0] now,
  input  logic [bdlp_pkg::CfgBits-1:0]  settle_ms,
  output bdlp_pkg::lane_evt_t           evt
);
  import bdlp_pkg::*;

  logic                raw_level;
  logic                stable_level;
  logic [TimeBits-1:0] change_time;
  logic                stable_level_next;
  logic                held;
  logic                changed;

  assign changed = (raw != raw_level);

  // A fresh change has elapsed zero, so it only passes with zero debounce.
  always_comb begin
    if (changed) begin
      held = (settle_ms == '0);
    end else begin
      held = ((now - change_time) >= TimeBits'(settle_ms));
    end
    stable_level_next = held ? raw : stable_level;
    evt.held    = held;
    evt.press   = held && (stable_level != raw) && !raw;
    evt.lift    = held && (stable_level != raw) && raw;
    evt.level   = stable_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      raw_level    <= 1'b1;
      stable_level <= 1'b1;
      change_time  <= '0;
    end else if (accept) begin
      raw_level    <= raw;
      stable_level <= stable_level_next;
      if (changed) begin
        change_time <= now;
      end
    end
  end

endmodule

### design/bdlp_merge.sv
// Merge stage: combines lane events in priority order, tracks the home
// long press and holds the pending event. Depends on bdlp_pkg.
module bdlp_merge (
  input  logic                                        clk,
  input  logic                                        rst,
  input  logic                                        accept,
  input  bdlp_pkg::lane_evt_t [bdlp_pkg::NumLanes-1:0] lane_evt,
  input  logic [bdlp_pkg::TimeBits-1:0]               now,
  input  logic [bdlp_pkg::CfgBits-1:0]                hold_ms,
  input  logic                                        take,
  output logic [bdlp_pkg::EvBits-1:0]                 event_next,
  output bdlp_pkg::merge_status_t                     status
);
  import bdlp_pkg::*;

  logic [TimeBits-1:0] home_press_time;
  logic                long_done;
  logic [EvBits-1:0]   pending_event;
  logic                long_done_next;
  logic                long_hit;
  logic                long_reached;

  always_comb begin
    // A press made stable in this sample has zero elapsed time.
    if (lane_evt[LaneHome].press) begin
      long_done_next = 1'b0;
      long_reached   = (hold_ms == '0);
    end else begin
      long_done_next = long_done;
      long_reached   = ((now - home_press_time) >= TimeBits'(hold_ms));
    end
    // No long press check while the home raw level is still settling.
    long_hit = lane_evt[LaneHome].held && !lane_evt[LaneHome].level &&
               !long_done_next && long_reached;

    event_next = pending_event;
    if (lane_evt[LanePrev].press) begin
      event_next = EvPrev;
    end
    if (lane_evt[LaneNext].press) begin
      event_next = EvNext;
    end
    if (lane_evt[LaneHome].lift && !long_done) begin
      event_next = EvHome;
    end
    if (long_hit) begin
      event_next     = EvHomeLong;
      long_done_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      home_press_time <= '0;
      long_done       <= 1'b0;
      pending_event   <= EvNone;
    end else if (accept) begin
      if (lane_evt[LaneHome].press) begin
        home_press_time <= now;
      end
      long_done     <= long_done_next;
      pending_event <= take ? EvNone : event_next;
    end
  end

  assign status.long_done = long_done;
  assign status.pending   = pending_event;

endmodule

### design/button_debounce_long_press.sv
// Top level of the three-button debouncer with home long press.
// Depends on bdlp_pkg, the channel interfaces, bdlp_lane, bdlp_merge, macros.
//
//   channel   dir   beat contents
//   sample    in    now_ms, prev_raw, next_raw, home_raw, take_event
//   result    out   event_res
//   cfg_*     in    write enable, register index, 16-bit data
//
// One sample per cycle while the result is not stalled; its event is in the result register in the cycle after.
// Three lanes debounce in parallel, the merge stage orders their events.
// The result register lets a new sample in while the last beat waits, as long
// as that beat is taken in the same cycle; a stalled result holds samples off.
// Reset leaves all buttons released, no pending event, registers at defaults.
`include "button_debounce_long_press_macros.svh"

module button_debounce_long_press (
  input  logic                            clk,
  input  logic                            rst,
  bdlp_sample_if.sink                     sample,
  bdlp_result_if.source                   result,
  input  logic                            cfg_we,
  input  logic [bdlp_pkg::CfgIdxBits-1:0] cfg_index,
  input  logic [bdlp_pkg::CfgBits-1:0]    cfg_data
);
  import bdlp_pkg::*;

  logic [CfgBits-1:0]              settle_ms;
  logic [CfgBits-1:0]              hold_ms;
  logic                            accept;
  logic [NumLanes-1:0]             raw_bits;
  lane_evt_t [NumLanes-1:0]        lane_evt;
  logic [EvBits-1:0]               event_next;
  merge_status_t                   status;
  logic                            res_valid;
  logic [EvBits-1:0]               res_event;
  logic                            long_new;

  always_ff @(posedge clk) begin
    if (rst) begin
      settle_ms <= DebounceReset;
      hold_ms   <= LongPressReset;
    end else if (cfg_we) begin
      case (cfg_index)
        RegDebounce:  settle_ms <= cfg_data;
        RegLongPress: hold_ms   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign sample.ready = !res_valid || result.ready;
  assign accept       = sample.valid && sample.ready;

  assign raw_bits[LanePrev] = sample.prev_raw;
  assign raw_bits[LaneNext] = sample.next_raw;
  assign raw_bits[LaneHome] = sample.home_raw;

  for (genvar i = 0; i < NumLanes; i++) begin : g_lane
    bdlp_lane u_lane (
      .clk       (clk),
      .rst       (rst),
      .accept    (accept),
      .raw       (raw_bits[i]),
      .now       (sample.now_ms),
      .settle_ms (settle_ms),
      .evt       (lane_evt[i])
    );
  end

  bdlp_merge u_merge (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .lane_evt   (lane_evt),
    .now        (sample.now_ms),
    .hold_ms    (hold_ms),
    .take       (sample.take_event),
    .event_next (event_next),
    .status     (status)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_event <= event_next;
    end
  end

  assign result.valid     = res_valid;
  assign result.event_res = res_event;

  // A long press that is new in this sample, not one still pending from before.
  assign long_new = (event_next == EvHomeLong) && (status.pending != EvHomeLong);

  // Kept event matches what was just reported; a fetch empties it.
  `BDLP_ASSERT_NEXT(a_keep_pending, clk, rst, accept && !sample.take_event, status.pending == result.event_res)
  `BDLP_ASSERT_NEXT(a_take_clears, clk, rst, accept && sample.take_event, status.pending == EvNone)
  `BDLP_ASSERT_NEXT(a_long_marks, clk, rst, accept && long_new, status.long_done)
  `BDLP_ASSERT_NOW(a_stall_blocks, clk, rst, res_valid && !result.ready, !sample.ready)

endmodule
